// ----- src/bfa_pkg.sv -----
package bfa_pkg;

  typedef enum logic [1:0] {
    REQ_ALLOC = 2'd0,
    REQ_SET   = 2'd1,
    REQ_CLEAR = 2'd2,
    REQ_BAD   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_SHORT = 2'd1,
    ST_RANGE = 2'd2,
    ST_RSVD  = 2'd3
  } status_t;

  localparam int unsigned REQ_W    = 2;
  localparam int unsigned START_W  = 12;
  localparam int unsigned COUNT_W  = 13;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned ADDR_W   = 24;
  localparam int unsigned LIMIT_W  = 13;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'd4096;

endpackage

// ----- src/bfa_if.sv -----
interface bfa_req_if;
  logic                           valid;
  logic                           ready;
  logic [bfa_pkg::REQ_W-1:0]      req_type;
  logic [bfa_pkg::START_W-1:0]    start_frame;
  logic [bfa_pkg::COUNT_W-1:0]    frame_count;
  modport source (output valid, req_type, start_frame, frame_count, input ready);
  modport sink   (input valid, req_type, start_frame, frame_count, output ready);
endinterface

interface bfa_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [bfa_pkg::STATUS_W-1:0]   status;
  logic [bfa_pkg::START_W-1:0]    first_frame;
  logic [bfa_pkg::ADDR_W-1:0]     base_address;
  modport source (output valid, status, first_frame, base_address, input ready);
  modport sink   (input valid, status, first_frame, base_address, output ready);
endinterface

interface bfa_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [bfa_pkg::LIMIT_W-1:0]    data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ----- src/bitmap_frame_allocator.sv -----
// Bitmap first-fit page frame allocator.
// Requests arrive as beats on in (req_type, start_frame, frame_count); every
// request gives exactly one result beat on out (status, first_frame,
// base_address). The cfg channel writes frame_limit, the number of frames
// from zero that allocation searches; it is always ready.
// The bitmap lives in a memory of one word per row, read into a
// register. An allocate scans rows in order, one row per cycle, tracking the
// current free run; once the run is found a second pass rewrites the rows
// it covers, reading and then writing each row in turn. Mark requests do the
// same read-modify-write pass over their rows. An allocate scans at most
// frame_limit/WORD_BITS rows rounded up, with frame_limit capped at
// NUM_FRAMES. Requests with a zero count or an unknown type answer with
// ST_RANGE without touching the bitmap.
// After reset a clearing pass writes zero to every row, one per cycle;
// in.ready stays low until it ends. The result waits in an output
// register; while out.ready is low the block holds it and accepts no new
// request. One request is worked at a time.
module bitmap_frame_allocator #(
  parameter int unsigned NUM_FRAMES  = 4096,
  parameter int unsigned WORD_BITS   = 64,
  parameter int unsigned FRAME_BYTES = 4096
) (
  input  logic   clk,
  input  logic   rst_n,
  bfa_req_if.sink   in_ch,
  bfa_rsp_if.source out_ch,
  bfa_cfg_if.sink   cfg_ch
);

  localparam int unsigned NUM_WORDS = (NUM_FRAMES + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned AW = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int unsigned BW = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
  localparam int unsigned FW = $clog2(NUM_FRAMES + 1) + 1;
  localparam int unsigned SH = $clog2(FRAME_BYTES);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_SCAN, S_RD, S_WR, S_DONE
  } state_t;

  state_t state_r;
  logic [WORD_BITS-1:0] mem [NUM_WORDS];
  logic [WORD_BITS-1:0] rdata_r;
  logic [AW-1:0]        clr_r;
  logic [bfa_pkg::LIMIT_W-1:0] limit_r;

  logic [bfa_pkg::REQ_W-1:0] req_r;
  logic [FW-1:0] cnt_r, first_r, last_r, cand_r, limit_eff_r;
  logic [AW:0]   row_r;
  logic          rvalid_r;
  logic [AW:0]   rrow_r;

  logic          ovalid_r;
  logic [bfa_pkg::STATUS_W-1:0] ostat_r;
  logic [bfa_pkg::START_W-1:0]  ofirst_r;

  assign in_ch.ready  = (state_r == S_IDLE) && !ovalid_r;
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = ovalid_r;
  assign out_ch.status = ostat_r;
  assign out_ch.first_frame = ofirst_r;
  assign out_ch.base_address = bfa_pkg::ADDR_W'({ofirst_r, SH'(0)});

  // Scan one row: walk its bits, keeping the first-fit candidate.
  logic [FW-1:0] scan_cand;
  logic          scan_hit;
  logic [FW-1:0] scan_base;
  always_comb begin
    logic [FW-1:0] f;
    logic [FW-1:0] c;
    logic          h;
    c = cand_r;
    h = 1'b0;
    scan_base = FW'(rrow_r) << BW;
    for (int b = 0; b < WORD_BITS; b++) begin
      f = scan_base + FW'(b);
      if (!h && f < limit_eff_r) begin
        if (rdata_r[b] || (f >= FW'(NUM_FRAMES))) c = f + FW'(1);
        if ((f + FW'(1) - c) == cnt_r) h = 1'b1;
      end
    end
    scan_cand = c;
    scan_hit  = h;
  end

  // Row mask for frames first_r .. last_r.
  logic [WORD_BITS-1:0] wmask;
  always_comb begin
    logic [FW-1:0] f;
    for (int b = 0; b < WORD_BITS; b++) begin
      f = (FW'(row_r) << BW) + FW'(b);
      wmask[b] = (f >= first_r) && (f <= last_r);
    end
  end

  logic [FW-1:0] in_end;
  assign in_end = FW'(in_ch.start_frame) + FW'(in_ch.frame_count);

  always_ff @(posedge clk) begin
    rvalid_r <= rst_n && (state_r == S_SCAN) && (row_r < (AW+1)'(NUM_WORDS));
    if (state_r == S_CLEAR) begin
      mem[clr_r] <= '0;
    end else if (state_r == S_WR) begin
      if (req_r == bfa_pkg::REQ_CLEAR) mem[row_r[AW-1:0]] <= rdata_r & ~wmask;
      else                              mem[row_r[AW-1:0]] <= rdata_r | wmask;
    end
    if (state_r == S_SCAN || state_r == S_RD) begin
      rdata_r  <= mem[row_r[AW-1:0]];
      rrow_r   <= row_r;
    end
    if (!rst_n) begin
      state_r  <= S_CLEAR;
      clr_r    <= '0;
      limit_r  <= bfa_pkg::LIMIT_RESET;
      ovalid_r <= 1'b0;
    end else begin
      if (cfg_ch.valid) limit_r <= cfg_ch.data;
      if (ovalid_r && out_ch.ready) ovalid_r <= 1'b0;
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + AW'(1);
          if (clr_r == AW'(NUM_WORDS - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (in_ch.valid && in_ch.ready) begin
            req_r    <= in_ch.req_type;
            cnt_r    <= FW'(in_ch.frame_count);
            ofirst_r <= '0;
            if (in_ch.frame_count == '0 || in_ch.req_type == bfa_pkg::REQ_BAD) begin
              ostat_r <= bfa_pkg::ST_RANGE;
              state_r <= S_DONE;
            end else if (in_ch.req_type == bfa_pkg::REQ_ALLOC) begin
              cand_r  <= '0;
              row_r   <= '0;
              limit_eff_r <= (FW'(limit_r) > FW'(NUM_FRAMES)) ? FW'(NUM_FRAMES)
                                                               : FW'(limit_r);
              state_r <= S_SCAN;
            end else if (in_end > FW'(NUM_FRAMES)) begin
              ostat_r <= bfa_pkg::ST_RANGE;
              state_r <= S_DONE;
            end else begin
              first_r <= FW'(in_ch.start_frame);
              last_r  <= in_end - FW'(1);
              row_r   <= (AW+1)'(in_ch.start_frame >> BW);
              ostat_r <= bfa_pkg::ST_OK;
              state_r <= S_RD;
            end
          end
        end
        S_SCAN: begin
          if (rvalid_r) begin
            cand_r <= scan_cand;
            if (scan_hit) begin
              first_r  <= scan_cand;
              last_r   <= scan_cand + cnt_r - FW'(1);
              row_r    <= (AW+1)'(scan_cand >> BW);
              ostat_r  <= bfa_pkg::ST_OK;
              ofirst_r <= bfa_pkg::START_W'(scan_cand);
              state_r  <= S_RD;
            end else if ((scan_base + FW'(WORD_BITS)) >= limit_eff_r) begin
              ostat_r <= bfa_pkg::ST_SHORT;
              state_r <= S_DONE;
            end else begin
              row_r <= row_r + (AW+1)'(1);
            end
          end else if ((FW'(row_r) << BW) >= limit_eff_r) begin
            ostat_r <= bfa_pkg::ST_SHORT;
            state_r <= S_DONE;
          end else begin
            row_r <= row_r + (AW+1)'(1);
          end
        end
        S_RD: state_r <= S_WR;
        S_WR: begin
          if ((FW'(row_r) << BW) + FW'(WORD_BITS) > last_r) state_r <= S_DONE;
          else begin
            row_r   <= row_r + (AW+1)'(1);
            state_r <= S_RD;
          end
        end
        S_DONE: begin
          ovalid_r <= 1'b1;
          state_r  <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- sim/tb.sv -----
module tb;

  localparam int unsigned NFR = 4096;
  localparam int unsigned FRB = 4096;
  localparam int unsigned CYCLE_LIMIT = 3000000;

  typedef struct packed {
    bfa_pkg::status_t                   status;
    logic [bfa_pkg::START_W-1:0] first_frame;
    logic [bfa_pkg::ADDR_W-1:0]  base_address;
  } alloc_result_t;

  class frame_scoreboard;
    bit used_map [NFR];
    int unsigned limit;
    alloc_result_t pending [$];
    int unsigned errors;
    int unsigned checked;

    function void clear_all();
      foreach (used_map[i]) used_map[i] = 1'b0;
      limit = bfa_pkg::LIMIT_RESET;
      errors = 0;
      checked = 0;
    endfunction

    function void set_limit(int unsigned v);
      limit = v;
    endfunction

    function void note_request(logic [1:0] rq, int unsigned st, int unsigned cnt);
      alloc_result_t r;
      int unsigned lim;
      int unsigned cand;
      r.status = bfa_pkg::ST_RANGE;
      r.first_frame = '0;
      r.base_address = '0;
      if (cnt == 0 || rq == bfa_pkg::REQ_BAD) begin
        r.status = bfa_pkg::ST_RANGE;
      end else if (rq == bfa_pkg::REQ_ALLOC) begin
        lim = (limit > NFR) ? NFR : limit;
        cand = 0;
        r.status = bfa_pkg::ST_SHORT;
        for (int unsigned i = 0; i < lim; i++) begin
          if (used_map[i]) cand = i + 1;
          if (i + 1 - cand == cnt) begin
            for (int unsigned j = cand; j < cand + cnt; j++) used_map[j] = 1'b1;
            r.status = bfa_pkg::ST_OK;
            r.first_frame = cand[bfa_pkg::START_W-1:0];
            r.base_address = 24'(cand * FRB);
            break;
          end
        end
      end else if (st + cnt > NFR) begin
        r.status = bfa_pkg::ST_RANGE;
      end else begin
        for (int unsigned j = st; j < st + cnt; j++) used_map[j] = (rq == bfa_pkg::REQ_SET);
        r.status = bfa_pkg::ST_OK;
      end
      pending.push_back(r);
    endfunction

    function void check_result(alloc_result_t got);
      alloc_result_t exp;
      checked++;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat %h", $time, got);
        return;
      end
      exp = pending.pop_front();
      if (got.status !== exp.status) begin
        errors++;
        $display("%0t: status expected %0d actual %0d", $time, exp.status, got.status);
      end
      if (got.first_frame !== exp.first_frame) begin
        errors++;
        $display("%0t: first_frame expected %0d actual %0d", $time, exp.first_frame,
                 got.first_frame);
      end
      if (got.base_address !== exp.base_address) begin
        errors++;
        $display("%0t: base_address expected %h actual %h", $time, exp.base_address,
                 got.base_address);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bfa_req_if in_ch();
  bfa_rsp_if out_ch();
  bfa_cfg_if cfg_ch();

  bitmap_frame_allocator u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  frame_scoreboard sb;
  int unsigned cycles;
  bit calm;
  int unsigned sent;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.req_type = '0;
    in_ch.start_frame = '0;
    in_ch.frame_count = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    rst_n = 1'b0;
    sb = new();
    sb.clear_all();
    calm = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result({bfa_pkg::status_t'(out_ch.status), out_ch.first_frame,
                       out_ch.base_address});
    out_ch.ready <= calm ? 1'b1 : ($urandom_range(99) >= 16);
  end

  task automatic send_req(logic [1:0] rq, int unsigned st, int unsigned cnt);
    if (!calm && $urandom_range(99) < 16) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < 16) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.req_type <= rq;
    in_ch.start_frame <= st[bfa_pkg::START_W-1:0];
    in_ch.frame_count <= cnt[bfa_pkg::COUNT_W-1:0];
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_request(rq, st, cnt);
    sent++;
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_limit(int unsigned v);
    wait_idle();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= v[bfa_pkg::LIMIT_W-1:0];
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    sb.set_limit(v);
  endtask

  task automatic random_req();
    int unsigned p;
    int unsigned cnt;
    p = $urandom_range(99);
    cnt = ($urandom_range(9) == 0) ? $urandom_range(8191) : $urandom_range(200);
    if (p < 50) send_req(bfa_pkg::REQ_ALLOC, $urandom_range(4095), cnt);
    else if (p < 70) send_req(bfa_pkg::REQ_SET, $urandom_range(4095), cnt);
    else if (p < 95) send_req(bfa_pkg::REQ_CLEAR, $urandom_range(4095),
                              ($urandom_range(3) == 0) ? $urandom_range(8191)
                                                       : $urandom_range(600));
    else send_req(bfa_pkg::REQ_BAD, $urandom_range(4095), cnt);
  endtask

  initial begin
    sent = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_req(bfa_pkg::REQ_ALLOC, 0, 1);
    send_req(bfa_pkg::REQ_ALLOC, 4095, 63);
    send_req(bfa_pkg::REQ_ALLOC, 0, 0);
    send_req(bfa_pkg::REQ_BAD, 12, 5);
    send_req(bfa_pkg::REQ_SET, 100, 50);
    send_req(bfa_pkg::REQ_ALLOC, 0, 40);
    send_req(bfa_pkg::REQ_ALLOC, 0, 4096);
    send_req(bfa_pkg::REQ_CLEAR, 0, 4096);
    send_req(bfa_pkg::REQ_ALLOC, 0, 4096);
    send_req(bfa_pkg::REQ_ALLOC, 0, 1);
    send_req(bfa_pkg::REQ_CLEAR, 4095, 1);
    send_req(bfa_pkg::REQ_SET, 4095, 2);
    send_req(bfa_pkg::REQ_SET, 4000, 8191);
    send_req(bfa_pkg::REQ_CLEAR, 0, 8191);
    send_req(bfa_pkg::REQ_SET, 0, 0);
    send_req(bfa_pkg::REQ_CLEAR, 0, 4096);
    write_limit(0);
    send_req(bfa_pkg::REQ_ALLOC, 0, 1);
    write_limit(8191);
    send_req(bfa_pkg::REQ_ALLOC, 0, 4096);
    send_req(bfa_pkg::REQ_CLEAR, 0, 4096);
    write_limit(64);
    send_req(bfa_pkg::REQ_ALLOC, 0, 64);
    send_req(bfa_pkg::REQ_ALLOC, 0, 1);
    send_req(bfa_pkg::REQ_CLEAR, 0, 4096);
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          write_limit(4096);
        end
        1: begin
          write_limit(1 + $urandom_range(700));
        end
        2: begin
          write_limit(4096 + $urandom_range(4095));
          calm = 1'b1;
        end
        default: begin
          write_limit(4096);
          calm = 1'b0;
        end
      endcase
      for (int k = 0; k < 95; k++) random_req();
    end
    wait_idle();
    $display("Ran %0d requests and %0d result beats across several frame limits.", sent,
             sb.checked);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
src/bfa_pkg.sv
src/bfa_if.sv
src/bitmap_frame_allocator.sv
sim/tb.sv
